// File: hw/rtl/message_ring_queue_dedup_unit_macros.svh
// assertion macros used by message_ring_queue_dedup_unit.sv
`ifndef MESSAGE_RING_QUEUE_DEDUP_UNIT_MACROS_SVH
`define MESSAGE_RING_QUEUE_DEDUP_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define MRQD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define MRQD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mrqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrqd_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int REQ_W   = 3;
   localparam int KIND_W  = 16;
   localparam int VALUE_W = 16;
   localparam int ENTRY_W = KIND_W + VALUE_W;
   localparam int FILL_W  = 5;

   // request codes
   localparam logic [REQ_W-1:0] REQ_PUSH_BACK   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_UNIQUE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP         = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CHECK       = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd5;

   // pointer update commands from the sequencer
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop;
      logic clear;
   } ptr_ctrl_type;

   // pointer and count status toward the sequencer
   typedef struct packed {
      logic [PTR_W-1:0] wr_pos;
      logic [PTR_W-1:0] rd_pos;
      logic [PTR_W-1:0] rd_prev;
      logic [CNT_W-1:0] count;
      logic             full;
      logic             empty;
   } ptr_stat_type;

   // ring increment with wrap
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // ring decrement with wrap
   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      ptr_prev = (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mrqd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mrqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/mrqd_ptrs.sv
`timescale 1ns / 1ps
`default_nettype none

module mrqd_ptrs
   import mrqd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ptr_ctrl_type ctrl,
   output ptr_stat_type      stat
);

   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0] rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // next pointer and count values
   always_comb begin
      wr_pos_in = wr_pos_ff;
      rd_pos_in = rd_pos_ff;
      count_in  = count_ff;
      if (ctrl.push_back) begin
         wr_pos_in = ptr_next(wr_pos_ff);
         count_in  = count_ff + 1'b1;
      end else if (ctrl.push_front) begin
         rd_pos_in = ptr_prev(rd_pos_ff);
         count_in  = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         rd_pos_in = ptr_next(rd_pos_ff);
         count_in  = count_ff - 1'b1;
      end else if (ctrl.clear) begin
         // read position plus count always equals the write position on the ring
         rd_pos_in = wr_pos_ff;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         rd_pos_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
         count_ff  <= count_in;
      end
   end

   // status toward the sequencer
   always_comb begin
      stat.wr_pos  = wr_pos_ff;
      stat.rd_pos  = rd_pos_ff;
      stat.rd_prev = ptr_prev(rd_pos_ff);
      stat.count   = count_ff;
      stat.full    = (count_ff >= CNT_W'(QUEUE_DEPTH));
      stat.empty   = (count_ff == '0);
   end

endmodule

`default_nettype wire

// File: hw/rtl/message_ring_queue_dedup_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular queue of QUEUE_DEPTH message entries (16-bit kind, 16-bit value) with push back,
// unique push back, push front, pop, check and clear. A request is taken when start is high
// and busy is low; its single result appears on the rsp_ ports for exactly one cycle,
// marked by rsp_strobe, and must be captured then since the receiver cannot stall the block.
// Pushes, clear, unused codes and a pop from an empty queue finish in the execute state;
// a pop that returns an entry first reads the entry RAM and finishes in the pop state. Check
// and unique push walk the queued entries through the entry RAM read port one per cycle,
// ending early on the first match. busy falls in the cycle the result is shown, so the next
// request may be taken in that cycle.

`include "message_ring_queue_dedup_unit_macros.svh"

module message_ring_queue_dedup_unit
   import mrqd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [REQ_W-1:0]   req_type,
   input  wire logic [KIND_W-1:0]  req_msg_kind,
   input  wire logic [VALUE_W-1:0] req_msg_value,
   output logic                    rsp_strobe,
   output logic                    rsp_accepted,
   output logic                    rsp_duplicate_found,
   output logic      [KIND_W-1:0]  rsp_out_kind,
   output logic      [VALUE_W-1:0] rsp_out_value,
   output logic      [FILL_W-1:0]  rsp_fill_count
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_POP
   } state_type;

   state_type        state_ff, state_in;
   logic [REQ_W-1:0] req_ff, req_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [PTR_W-1:0] scan_pos_ff, scan_pos_in;
   logic [CNT_W-1:0] scan_left_ff, scan_left_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_accepted_ff, rsp_accepted_in;
   logic               rsp_dup_ff, rsp_dup_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   ptr_ctrl_type ctrl;
   ptr_stat_type stat;

   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic               rd_en;
   logic [PTR_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] entry;
   logic               hit;

   // entry storage
   mrqd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ring pointers and fill count
   mrqd_ptrs u_ptrs (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   assign entry = {kind_ff, value_ff};
   assign hit   = (rd_data == entry);

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      kind_in         = kind_ff;
      value_in        = value_ff;
      scan_pos_in     = scan_pos_ff;
      scan_left_in    = scan_left_ff;
      rsp_strobe_in   = 1'b0;
      rsp_accepted_in = 1'b0;
      rsp_dup_in      = 1'b0;
      rsp_kind_in     = '0;
      rsp_value_in    = '0;
      ctrl            = '0;
      wr_en           = 1'b0;
      wr_addr         = stat.wr_pos;
      rd_en           = 1'b0;
      rd_addr         = stat.rd_pos;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_type;
               kind_in  = req_msg_kind;
               value_in = req_msg_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (req_ff) inside
               REQ_PUSH_BACK: begin
                  if (!stat.full) begin
                     wr_en           = 1'b1;
                     ctrl.push_back  = 1'b1;
                     rsp_accepted_in = 1'b1;
                  end
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
               REQ_PUSH_UNIQUE, REQ_CHECK: begin
                  if (stat.empty) begin
                     // nothing to scan, so no duplicate
                     if (req_ff == REQ_PUSH_UNIQUE && !stat.full) begin
                        wr_en           = 1'b1;
                        ctrl.push_back  = 1'b1;
                        rsp_accepted_in = 1'b1;
                     end
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     rd_en        = 1'b1;
                     scan_pos_in  = stat.rd_pos;
                     scan_left_in = stat.count;
                     state_in     = S_SCAN;
                  end
               end
               REQ_PUSH_FRONT: begin
                  if (!stat.full) begin
                     wr_en           = 1'b1;
                     wr_addr         = stat.rd_prev;
                     ctrl.push_front = 1'b1;
                     rsp_accepted_in = 1'b1;
                  end
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
               REQ_POP: begin
                  if (stat.empty) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_POP;
                  end
               end
               REQ_CLEAR: begin
                  ctrl.clear    = 1'b1;
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            // compare the entry read last cycle, stop on a match or the last entry
            if (hit || scan_left_ff == CNT_W'(1)) begin
               rsp_dup_in = hit;
               if (req_ff == REQ_PUSH_UNIQUE && !hit && !stat.full) begin
                  wr_en           = 1'b1;
                  ctrl.push_back  = 1'b1;
                  rsp_accepted_in = 1'b1;
               end
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = ptr_next(scan_pos_ff);
               scan_pos_in  = ptr_next(scan_pos_ff);
               scan_left_in = scan_left_ff - 1'b1;
            end
         end
         S_POP: begin
            ctrl.pop        = 1'b1;
            rsp_accepted_in = 1'b1;
            rsp_kind_in     = rd_data[ENTRY_W-1:VALUE_W];
            rsp_value_in    = rd_data[VALUE_W-1:0];
            rsp_strobe_in   = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         req_ff          <= req_in;
         kind_ff         <= kind_in;
         value_ff        <= value_in;
         scan_pos_ff     <= scan_pos_in;
         scan_left_ff    <= scan_left_in;
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_dup_ff      <= rsp_dup_in;
         rsp_kind_ff     <= rsp_kind_in;
         rsp_value_ff    <= rsp_value_in;
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_accepted        = rsp_accepted_ff;
   assign rsp_duplicate_found = rsp_dup_ff;
   assign rsp_out_kind        = rsp_kind_ff;
   assign rsp_out_value       = rsp_value_ff;
   // the count register updates on the same edge as the strobe
   assign rsp_fill_count      = FILL_W'(stat.count);

   // checks
   `MRQD_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= CNT_W'(QUEUE_DEPTH), "fill count over depth")
   `MRQD_ASSERT_NOW(a_strobe_after_work, rsp_strobe, $past(busy), "result without a request")
   `MRQD_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe, "result shown twice")
   `MRQD_ASSERT_NOW(a_dup_not_stored, rsp_strobe && rsp_duplicate_found, !rsp_accepted, "dup stored")

endmodule

`default_nettype wire

// File: tb/message_ring_queue_dedup_unit_tb.sv
`timescale 1ns / 1ps

module message_ring_queue_dedup_unit_tb;
   import mrqd_pkg::*;

   // request codes the block ignores
   localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS = 2000;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 4;
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 10;
   localparam int NUM_ROWS = 23;

   // one result as seen on the rsp_ ports
   typedef struct packed {
      logic               accepted;
      logic               duplicate_found;
      logic [KIND_W-1:0]  out_kind;
      logic [VALUE_W-1:0] out_value;
      logic [FILL_W-1:0]  fill_count;
   } queue_rsp_type;

   // one row of the directed table; reps pushes consecutive values
   typedef struct packed {
      logic [REQ_W-1:0]   req;
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [4:0]         reps;
      logic               typed;
      queue_rsp_type      rsp;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // empty queue after reset
      '{REQ_POP,         16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd0}},
      '{REQ_CHECK,       16'hFFFF, 16'hFFFF, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd0}},
      '{REQ_CLEAR,       16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd0}},
      '{REQ_SPARE_A,     16'hFFFF, 16'hFFFF, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd0}},
      // single entry, duplicate detection, front insert with wrap
      '{REQ_PUSH_BACK,   16'hFFFF, 16'hFFFF, 5'd1,  1'b1, '{1'b1, 1'b0, 16'h0, 16'h0, 5'd1}},
      '{REQ_PUSH_UNIQUE, 16'hFFFF, 16'hFFFF, 5'd1,  1'b1, '{1'b0, 1'b1, 16'h0, 16'h0, 5'd1}},
      '{REQ_CHECK,       16'hFFFF, 16'hFFFF, 5'd1,  1'b1, '{1'b0, 1'b1, 16'h0, 16'h0, 5'd1}},
      '{REQ_PUSH_FRONT,  16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b1, 1'b0, 16'h0, 16'h0, 5'd2}},
      '{REQ_POP,         16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b1, 1'b0, 16'h0, 16'h0, 5'd1}},
      '{REQ_POP,         16'h0000, 16'h0000, 5'd1,  1'b1,
        '{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 5'd0}},
      // fill to the brim
      '{REQ_PUSH_FRONT,  16'h1234, 16'hABCD, 5'd1,  1'b0, '0},
      '{REQ_PUSH_BACK,   16'h5555, 16'hAAAA, 5'd15, 1'b0, '0},
      // full queue drops every kind of push
      '{REQ_PUSH_BACK,   16'hAAAA, 16'h5555, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd16}},
      '{REQ_PUSH_UNIQUE, 16'h1234, 16'hABCD, 5'd1,  1'b1, '{1'b0, 1'b1, 16'h0, 16'h0, 5'd16}},
      '{REQ_PUSH_UNIQUE, 16'h0F0F, 16'hF0F0, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd16}},
      '{REQ_PUSH_FRONT,  16'h8000, 16'h0001, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd16}},
      '{REQ_CHECK,       16'h5555, 16'hAAB8, 5'd1,  1'b0, '0},
      '{REQ_SPARE_B,     16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd16}},
      '{REQ_POP,         16'h0000, 16'h0000, 5'd1,  1'b1,
        '{1'b1, 1'b0, 16'h1234, 16'hABCD, 5'd15}},
      // clear, then reuse
      '{REQ_CLEAR,       16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd0}},
      '{REQ_POP,         16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b0, 1'b0, 16'h0, 16'h0, 5'd0}},
      '{REQ_PUSH_UNIQUE, 16'h8000, 16'h0001, 5'd1,  1'b1, '{1'b1, 1'b0, 16'h0, 16'h0, 5'd1}},
      '{REQ_CHECK,       16'h8001, 16'h0001, 5'd1,  1'b0, '0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [REQ_W-1:0]   req_type = '0;
   logic [KIND_W-1:0]  req_msg_kind = '0;
   logic [VALUE_W-1:0] req_msg_value = '0;
   logic               busy;
   logic               rsp_strobe;
   logic               rsp_accepted;
   logic               rsp_duplicate_found;
   logic [KIND_W-1:0]  rsp_out_kind;
   logic [VALUE_W-1:0] rsp_out_value;
   logic [FILL_W-1:0]  rsp_fill_count;

   // predicted queue contents
   logic [ENTRY_W-1:0] ring_store [QUEUE_DEPTH];
   int                 ring_wr = 0;
   int                 ring_rd = 0;
   int                 ring_count = 0;

   queue_rsp_type      pending_rsps [$];
   int                 fail_count = 0;
   int                 cycle_count = 0;
   int                 stretch_left = 0;
   logic               no_idle = 1'b0;

   message_ring_queue_dedup_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_msg_kind        (req_msg_kind),
      .req_msg_value       (req_msg_value),
      .rsp_strobe          (rsp_strobe),
      .rsp_accepted        (rsp_accepted),
      .rsp_duplicate_found (rsp_duplicate_found),
      .rsp_out_kind        (rsp_out_kind),
      .rsp_out_value       (rsp_out_value),
      .rsp_fill_count      (rsp_fill_count)
   );

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // scan the queued entries, oldest first
   function automatic logic entry_queued(input logic [ENTRY_W-1:0] entry);
      int p;
      p = ring_rd;
      for (int n = 0; n < ring_count; n++) begin
         if (ring_store[p] == entry) return 1'b1;
         p = (p + 1) % QUEUE_DEPTH;
      end
      return 1'b0;
   endfunction

   function automatic void ring_append(input logic [ENTRY_W-1:0] entry);
      ring_store[ring_wr] = entry;
      ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
      ring_count++;
   endfunction

   // apply one request to the predicted queue and return its result
   function automatic queue_rsp_type queue_apply(input logic [REQ_W-1:0] req,
                                                 input logic [KIND_W-1:0] kind,
                                                 input logic [VALUE_W-1:0] value);
      queue_rsp_type      r;
      logic [ENTRY_W-1:0] entry;
      logic               full;
      r = '0;
      entry = {kind, value};
      full = (ring_count >= QUEUE_DEPTH);
      case (req)
         REQ_PUSH_BACK: begin
            if (!full) begin
               ring_append(entry);
               r.accepted = 1'b1;
            end
         end
         REQ_PUSH_UNIQUE: begin
            r.duplicate_found = entry_queued(entry);
            if (!full && !r.duplicate_found) begin
               ring_append(entry);
               r.accepted = 1'b1;
            end
         end
         REQ_PUSH_FRONT: begin
            if (!full) begin
               ring_rd = (ring_rd == 0) ? QUEUE_DEPTH - 1 : ring_rd - 1;
               ring_store[ring_rd] = entry;
               ring_count++;
               r.accepted = 1'b1;
            end
         end
         REQ_POP: begin
            if (ring_count != 0) begin
               {r.out_kind, r.out_value} = ring_store[ring_rd];
               ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
               ring_count--;
               r.accepted = 1'b1;
            end
         end
         REQ_CHECK: begin
            r.duplicate_found = entry_queued(entry);
         end
         REQ_CLEAR: begin
            ring_rd = (ring_rd + ring_count) % QUEUE_DEPTH;
            ring_count = 0;
         end
         default: begin
         end
      endcase
      r.fill_count = FILL_W'(ring_count);
      return r;
   endfunction

   // field value biased toward corners and a small pool
   function automatic logic [15:0] draw_field();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3, 4: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   // one transfer: idle gap, drive, wait for the handshake, record the expectation
   task automatic send_request(input logic [REQ_W-1:0] req, input logic [KIND_W-1:0] kind,
                               input logic [VALUE_W-1:0] value, input logic typed,
                               input queue_rsp_type typed_rsp);
      int            gap;
      queue_rsp_type predicted;
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(20, 80);
         no_idle = ($urandom_range(0, 3) == 0);
      end
      stretch_left--;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= req;
      req_msg_kind <= kind;
      req_msg_value <= value;
      do @(posedge clock); while (busy);
      predicted = queue_apply(req, kind, value);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic note_failure(input string what, input queue_rsp_type want,
                               input queue_rsp_type got);
      string want_text;
      string got_text;
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         want_text = $sformatf("acc=%b dup=%b kind=%h value=%h fill=%0d", want.accepted,
                               want.duplicate_found, want.out_kind, want.out_value,
                               want.fill_count);
         got_text = $sformatf("acc=%b dup=%b kind=%h value=%h fill=%0d", got.accepted,
                              got.duplicate_found, got.out_kind, got.out_value,
                              got.fill_count);
         $display("%0t %s: expected %s, got %s", $realtime, what, want_text, got_text);
      end
   endtask

   // result checking
   always @(posedge clock) begin
      queue_rsp_type got;
      queue_rsp_type want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_accepted, rsp_duplicate_found, rsp_out_kind, rsp_out_value, rsp_fill_count};
         if (pending_rsps.size() == 0) begin
            note_failure("unexpected result", '0, got);
         end else begin
            want = pending_rsps.pop_front();
            if (got.accepted !== want.accepted || got.duplicate_found !== want.duplicate_found ||
                got.out_kind !== want.out_kind || got.out_value !== want.out_value ||
                got.fill_count !== want.fill_count) begin
               note_failure("result mismatch", want, got);
            end
         end
      end
   end

   // stimulus
   initial begin
      int                 counted;
      int                 mode_left;
      int                 roll;
      logic               filling;
      logic [REQ_W-1:0]   req;
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;

      for (int i = 0; i < QUEUE_DEPTH; i++) ring_store[i] = '0;
      while (reset) @(posedge clock);

      // directed table
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int k = 0; k < DIRECTED_ROWS[r].reps; k++) begin
            send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].kind,
                         VALUE_W'(DIRECTED_ROWS[r].value + k), DIRECTED_ROWS[r].typed,
                         DIRECTED_ROWS[r].rsp);
         end
      end

      // random traffic, alternating fill-heavy and drain-heavy stretches
      counted = 0;
      mode_left = 0;
      filling = 1'b1;
      while (counted < RANDOM_ITEMS) begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 60);
            filling = ~filling;
         end
         mode_left--;
         roll = $urandom_range(0, 99);
         if (filling) begin
            req = (roll < 30) ? REQ_PUSH_BACK : (roll < 55) ? REQ_PUSH_UNIQUE :
                  (roll < 75) ? REQ_PUSH_FRONT : (roll < 85) ? REQ_POP :
                  (roll < 95) ? REQ_CHECK : (roll < 96) ? REQ_CLEAR : REQ_SPARE_A;
         end else begin
            req = (roll < 10) ? REQ_PUSH_BACK : (roll < 20) ? REQ_PUSH_UNIQUE :
                  (roll < 30) ? REQ_PUSH_FRONT : (roll < 80) ? REQ_POP :
                  (roll < 92) ? REQ_CHECK : (roll < 94) ? REQ_CLEAR : REQ_SPARE_A;
         end
         if (req == REQ_SPARE_A && $urandom_range(0, 1) == 1) req = REQ_SPARE_B;
         kind = draw_field();
         value = draw_field();
         // aim duplicate scans at entries that are really queued
         if ((req == REQ_PUSH_UNIQUE || req == REQ_CHECK) && ring_count != 0 &&
             $urandom_range(0, 1) == 1) begin
            {kind, value} = ring_store[(ring_rd + $urandom_range(0, ring_count - 1)) %
                                       QUEUE_DEPTH];
         end
         send_request(req, kind, value, 1'b0, '0);
         if (req != REQ_SPARE_A && req != REQ_SPARE_B) counted++;
      end
      start <= 1'b0;

      // drain and settle
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mrqd_pkg.sv
hw/rtl/mrqd_ram.sv
hw/rtl/mrqd_ptrs.sv
hw/rtl/message_ring_queue_dedup_unit.sv
tb/message_ring_queue_dedup_unit_tb.sv
